// ===== design/rcb_pkg.sv =====
// Shared types, constants and codes for the read coverage binning block.
// Used by every module of the block but rcb_ram; no dependencies.
package rcb_pkg;

    localparam int NUM_BINS  = 65536;
    localparam int NEAR_EDGE = 20;
    localparam int ADDR_W    = $clog2(NUM_BINS);

    localparam int DIV_W     = 32;
    localparam int DVS_W     = 16;
    localparam int DCNT_W    = $clog2(DIV_W);

    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam int CFG_AW    = 4;

    localparam logic       OP_ACCUM   = 1'b0;
    localparam logic       OP_READOUT = 1'b1;

    localparam logic [2:0] ST_LOW_QUAL     = 3'd1;
    localparam logic [2:0] ST_UNMAPPED     = 3'd2;
    localparam logic [2:0] ST_WRONG_DIST   = 3'd3;
    localparam logic [2:0] ST_WRONG_ORIENT = 3'd4;

    localparam logic [1:0] REG_BIN_SIZE = 2'd0;
    localparam logic [1:0] REG_MIN_QUAL = 2'd1;
    localparam logic [1:0] REG_SPAN_EN  = 2'd2;

    localparam logic [15:0] BIN_SIZE_RST = 16'd500;
    localparam logic [7:0]  MIN_QUAL_RST = 8'd10;

    typedef struct packed {
        logic               opcode;
        logic [2:0]         read_status;
        logic [15:0]        contig_base;
        logic [16:0]        contig_bins;
        logic [30:0]        position;
        logic [15:0]        read_length;
        logic [7:0]         map_quality;
        logic signed [31:0] insert_size;
        logic               has_split_tag;
        logic [15:0]        bin_index;
    } t_in_item;

    typedef struct packed {
        logic [31:0] base_sum;
        logic [31:0] quality_sum;
        logic [31:0] read_count;
        logic [31:0] span_pairs;
        logic [31:0] span_reads;
    } t_out_item;

    typedef struct packed {
        logic        is_readout;
        logic [15:0] bin_index;
        logic [15:0] cbase;
        logic [16:0] cbins;
        logic [31:0] e;
        logic [15:0] take0;
        logic [15:0] len;
        logic [7:0]  mq;
        logic [31:0] span_start;
        logic [16:0] pair_cnt;
        logic [16:0] rs_cnt;
    } t_cmd;

endpackage

// ===== design/rcb_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module rcb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/rcb_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on rcb_pkg.
module rcb_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rcb_pkg::DIV_W-1:0] i_dividend,
    input  logic [rcb_pkg::DVS_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [rcb_pkg::DIV_W-1:0] o_quot,
    output logic [rcb_pkg::DVS_W-1:0] o_rem
);

    logic                       r_busy;
    logic                       r_done;
    logic [rcb_pkg::DCNT_W-1:0] r_cnt;
    logic [rcb_pkg::DIV_W-1:0]  r_quot;
    logic [rcb_pkg::DVS_W-1:0]  r_rem;
    logic [rcb_pkg::DVS_W-1:0]  r_div;

    logic [rcb_pkg::DVS_W:0]    w_trial;
    logic [rcb_pkg::DVS_W:0]    w_sub;
    logic                       w_ge;
    logic [rcb_pkg::DVS_W-1:0]  w_newrem;

    assign w_trial  = {r_rem, r_quot[rcb_pkg::DIV_W-1]};
    assign w_ge     = (w_trial >= {1'b0, r_div});
    assign w_sub    = w_trial - {1'b0, r_div};
    assign w_newrem = w_ge ? w_sub[rcb_pkg::DVS_W-1:0] : w_trial[rcb_pkg::DVS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                // shift next dividend bit into the remainder, quotient bit into r_quot
                r_quot <= {r_quot[rcb_pkg::DIV_W-2:0], w_ge};
                r_rem  <= w_newrem;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == rcb_pkg::DCNT_W'(rcb_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== design/rcb_front.sv =====
// Front end: accepts items, finds the first bin and the span counts,
// and pushes one command per item that needs work. Depends on rcb_pkg, rcb_div.
module rcb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rcb_pkg::t_in_item i_in_data,
    input  logic [15:0]       i_bs,
    input  logic [7:0]        i_min_q,
    input  logic              i_span_en,
    input  logic              i_clear_busy,
    output logic              o_push,
    output rcb_pkg::t_cmd     o_cmd,
    input  logic              i_q_full
);

    typedef enum logic [6:0] {
        F_IDLE  = 7'b0000001,
        F_DPOS  = 7'b0000010,
        F_PREP  = 7'b0000100,
        F_DPAIR = 7'b0001000,
        F_RPREP = 7'b0010000,
        F_DREAD = 7'b0100000,
        F_PUSH  = 7'b1000000
    } t_fstate;

    t_fstate           r_state, n_state;
    rcb_pkg::t_in_item r_item, n_item;
    logic [31:0]       r_e, n_e;
    logic [15:0]       r_off, n_off;
    logic              r_near, n_near;
    logic [31:0]       r_start, n_start;
    logic [16:0]       r_pair_cnt, n_pair_cnt;
    logic [16:0]       r_rs_cnt, n_rs_cnt;

    logic              w_div_start;
    logic [31:0]       w_div_dvd;
    logic              w_div_done;
    logic [31:0]       w_quot;
    logic [15:0]       w_rem;

    logic              w_accept;
    logic              w_span_ok;
    logic [33:0]       w_n;
    logic              w_n_pos;
    logic [31:0]       w_pair_dvd;
    logic [18:0]       w_n2;
    logic              w_n2_pos;
    logic [31:0]       w_rs_dvd;
    logic [15:0]       w_room;

    function automatic logic [16:0] clamp_cnt(input logic [31:0] c, input logic [31:0] s,
                                              input logic [16:0] nb);
        logic [32:0] lim;
        lim = {16'b0, nb} - {1'b0, s};
        if ({1'b0, s} >= {16'b0, nb}) begin
            return 17'd0;
        end else if ({1'b0, c} < lim) begin
            return c[16:0];
        end else begin
            return lim[16:0];
        end
    endfunction

    rcb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (i_bs),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign o_in_ready = (r_state == F_IDLE) && !i_clear_busy;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_span_ok = (r_item.read_status != rcb_pkg::ST_WRONG_DIST) &&
                       (r_item.read_status != rcb_pkg::ST_WRONG_ORIENT) &&
                       i_span_en && (r_item.map_quality > i_min_q);

    // insert - bin_size + offset, two's complement
    assign w_n = {{2{r_item.insert_size[31]}}, r_item.insert_size}
               - {18'b0, i_bs} + {18'b0, r_off};
    assign w_n_pos    = !w_n[33] && (w_n != '0);
    assign w_pair_dvd = w_n[31:0] + {16'b0, i_bs} - 32'd1;

    assign w_n2 = {3'b0, r_item.read_length} - {3'b0, i_bs} + {3'b0, r_off}
                - (r_near ? {3'b0, i_bs} : 19'd0);
    assign w_n2_pos = !w_n2[18] && (w_n2 != '0);
    assign w_rs_dvd = {13'b0, w_n2} + {16'b0, i_bs} - 32'd1;

    assign w_room = i_bs - r_off;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_e         = r_e;
        n_off       = r_off;
        n_near      = r_near;
        n_start     = r_start;
        n_pair_cnt  = r_pair_cnt;
        n_rs_cnt    = r_rs_cnt;
        w_div_start = 1'b0;
        w_div_dvd   = '0;
        o_push      = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_item = i_in_data;
                    if (i_in_data.opcode == rcb_pkg::OP_READOUT) begin
                        n_state = F_PUSH;
                    end else if ((i_in_data.read_status == rcb_pkg::ST_LOW_QUAL) ||
                                 (i_in_data.read_status == rcb_pkg::ST_UNMAPPED)) begin
                        n_state = F_IDLE;  // drop the item
                    end else begin
                        w_div_start = 1'b1;
                        w_div_dvd   = {1'b0, i_in_data.position};
                        n_state     = F_DPOS;
                    end
                end
            end
            F_DPOS: begin
                if (w_div_done) begin
                    n_e     = w_quot;
                    n_off   = w_rem;
                    n_near  = (w_rem < 16'(rcb_pkg::NEAR_EDGE));
                    n_state = F_PREP;
                end
            end
            F_PREP: begin
                n_start = r_near ? (r_e + 32'd1) : r_e;
                if (w_span_ok && w_n_pos) begin
                    w_div_start = 1'b1;
                    w_div_dvd   = w_pair_dvd;
                    n_state     = F_DPAIR;
                end else begin
                    n_pair_cnt = '0;
                    n_state    = F_RPREP;
                end
            end
            F_DPAIR: begin
                if (w_div_done) begin
                    n_pair_cnt = clamp_cnt(w_quot - {31'b0, r_near}, r_start,
                                           r_item.contig_bins);
                    n_state    = F_RPREP;
                end
            end
            F_RPREP: begin
                if (w_span_ok && !r_item.has_split_tag && w_n2_pos) begin
                    w_div_start = 1'b1;
                    w_div_dvd   = w_rs_dvd;
                    n_state     = F_DREAD;
                end else begin
                    n_rs_cnt = '0;
                    n_state  = F_PUSH;
                end
            end
            F_DREAD: begin
                if (w_div_done) begin
                    n_rs_cnt = clamp_cnt(w_quot, r_start, r_item.contig_bins);
                    n_state  = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.is_readout = (r_item.opcode == rcb_pkg::OP_READOUT);
        o_cmd.bin_index  = r_item.bin_index;
        o_cmd.cbase      = r_item.contig_base;
        o_cmd.cbins      = r_item.contig_bins;
        o_cmd.e          = r_e;
        o_cmd.take0      = (r_item.read_length < w_room) ? r_item.read_length : w_room;
        o_cmd.len        = r_item.read_length;
        o_cmd.mq         = r_item.map_quality;
        o_cmd.span_start = r_start;
        o_cmd.pair_cnt   = r_pair_cnt;
        o_cmd.rs_cnt     = r_rs_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_item     <= n_item;
        r_e        <= n_e;
        r_off      <= n_off;
        r_near     <= n_near;
        r_start    <= n_start;
        r_pair_cnt <= n_pair_cnt;
        r_rs_cnt   <= n_rs_cnt;
    end

endmodule

// ===== design/rcb_queue.sv =====
// Short command queue between front and back end.
// Depends on rcb_pkg.
module rcb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rcb_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rcb_pkg::t_cmd o_data
);

    rcb_pkg::t_cmd              r_mem [rcb_pkg::QDEPTH];
    logic [rcb_pkg::QPTR_W-1:0] r_wp;
    logic [rcb_pkg::QPTR_W-1:0] r_rp;
    logic [rcb_pkg::QCNT_W-1:0] r_cnt;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_cnt == rcb_pkg::QCNT_W'(rcb_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == rcb_pkg::QPTR_W'(rcb_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == rcb_pkg::QPTR_W'(rcb_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== design/rcb_back.sv =====
// Back end: clears the bin stores after reset, then runs read-modify-write
// over the bins of each command and serves readouts. Depends on rcb_pkg, rcb_ram.
module rcb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_bs,
    input  logic               i_q_valid,
    input  rcb_pkg::t_cmd      i_q_data,
    output logic               o_pop,
    output logic               o_clear_busy,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rcb_pkg::t_out_item o_out_data
);

    typedef enum logic [9:0] {
        B_CLEAR = 10'b0000000001,
        B_IDLE  = 10'b0000000010,
        B_ARD   = 10'b0000000100,
        B_AWR   = 10'b0000001000,
        B_PRD   = 10'b0000010000,
        B_PWR   = 10'b0000100000,
        B_SRD   = 10'b0001000000,
        B_SWR   = 10'b0010000000,
        B_ORD   = 10'b0100000000,
        B_OCAP  = 10'b1000000000
    } t_bstate;

    t_bstate                    r_state, n_state;
    rcb_pkg::t_cmd              r_cmd, n_cmd;
    logic [31:0]                r_e, n_e;
    logic [15:0]                r_rem, n_rem;
    logic [15:0]                r_take, n_take;
    logic [16:0]                r_left, n_left;
    logic                       r_ok, n_ok;
    logic [rcb_pkg::ADDR_W-1:0] r_clr, n_clr;
    logic                       r_out_valid, n_out_valid;
    rcb_pkg::t_out_item         r_out, n_out;

    logic [32:0]                w_flat;
    logic                       w_ok;
    logic [15:0]                w_next_take;
    logic [rcb_pkg::ADDR_W-1:0] w_addr;
    logic                       w_we_acc, w_we_pair, w_we_rs, w_we_clr;
    logic [31:0]                w_rd_base, w_rd_q, w_rd_cnt, w_rd_pair, w_rd_rs;
    logic [31:0]                w_wd_base, w_wd_q, w_wd_cnt, w_wd_pair, w_wd_rs;
    logic                       w_oor;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    assign w_flat = {17'b0, r_cmd.cbase} + {1'b0, r_e};
    assign w_ok   = ({1'b0, r_e} < {16'b0, r_cmd.cbins}) &&
                    (w_flat < 33'(rcb_pkg::NUM_BINS));
    assign w_next_take = (r_rem < i_bs) ? r_rem : i_bs;
    assign w_oor  = ({16'b0, r_cmd.bin_index} >= 32'(rcb_pkg::NUM_BINS));

    always_comb begin
        case (r_state)
            B_CLEAR: w_addr = r_clr;
            B_ORD:   w_addr = rcb_pkg::ADDR_W'(r_cmd.bin_index);
            default: w_addr = w_flat[rcb_pkg::ADDR_W-1:0];
        endcase
    end

    assign w_wd_base = w_we_clr ? '0 : sat_add(w_rd_base, {16'b0, r_take});
    assign w_wd_q    = w_we_clr ? '0 : sat_add(w_rd_q, {24'b0, r_cmd.mq});
    assign w_wd_cnt  = w_we_clr ? '0 : sat_add(w_rd_cnt, 32'd1);
    assign w_wd_pair = w_we_clr ? '0 : sat_add(w_rd_pair, 32'd1);
    assign w_wd_rs   = w_we_clr ? '0 : sat_add(w_rd_rs, 32'd1);

    rcb_ram #(.WIDTH(32), .DEPTH(rcb_pkg::NUM_BINS)) u_base_ram (
        .i_clk(i_clk), .i_addr(w_addr), .i_we(w_we_acc || w_we_clr),
        .i_wdata(w_wd_base), .o_rdata(w_rd_base));
    rcb_ram #(.WIDTH(32), .DEPTH(rcb_pkg::NUM_BINS)) u_qual_ram (
        .i_clk(i_clk), .i_addr(w_addr), .i_we(w_we_acc || w_we_clr),
        .i_wdata(w_wd_q), .o_rdata(w_rd_q));
    rcb_ram #(.WIDTH(32), .DEPTH(rcb_pkg::NUM_BINS)) u_cnt_ram (
        .i_clk(i_clk), .i_addr(w_addr), .i_we(w_we_acc || w_we_clr),
        .i_wdata(w_wd_cnt), .o_rdata(w_rd_cnt));
    rcb_ram #(.WIDTH(32), .DEPTH(rcb_pkg::NUM_BINS)) u_pair_ram (
        .i_clk(i_clk), .i_addr(w_addr), .i_we(w_we_pair || w_we_clr),
        .i_wdata(w_wd_pair), .o_rdata(w_rd_pair));
    rcb_ram #(.WIDTH(32), .DEPTH(rcb_pkg::NUM_BINS)) u_rs_ram (
        .i_clk(i_clk), .i_addr(w_addr), .i_we(w_we_rs || w_we_clr),
        .i_wdata(w_wd_rs), .o_rdata(w_rd_rs));

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_e         = r_e;
        n_rem       = r_rem;
        n_take      = r_take;
        n_left      = r_left;
        n_ok        = r_ok;
        n_clr       = r_clr;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_pop       = 1'b0;
        w_we_acc    = 1'b0;
        w_we_pair   = 1'b0;
        w_we_rs     = 1'b0;
        w_we_clr    = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            B_CLEAR: begin
                w_we_clr = 1'b1;
                n_clr    = r_clr + 1'b1;
                if (r_clr == rcb_pkg::ADDR_W'(rcb_pkg::NUM_BINS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_q_data;
                    if (i_q_data.is_readout) begin
                        n_state = B_ORD;
                    end else begin
                        n_e     = i_q_data.e;
                        n_take  = i_q_data.take0;
                        n_rem   = i_q_data.len - i_q_data.take0;
                        n_state = B_ARD;
                    end
                end
            end
            B_ARD: begin
                n_ok    = w_ok;
                n_state = B_AWR;
            end
            B_AWR: begin
                w_we_acc = r_ok;
                if ((r_rem != '0) && (({1'b0, r_e} + 33'd1) < {16'b0, r_cmd.cbins})) begin
                    n_e     = r_e + 32'd1;
                    n_take  = w_next_take;
                    n_rem   = r_rem - w_next_take;
                    n_state = B_ARD;
                end else if (r_cmd.pair_cnt != '0) begin
                    n_e     = r_cmd.span_start;
                    n_left  = r_cmd.pair_cnt;
                    n_state = B_PRD;
                end else if (r_cmd.rs_cnt != '0) begin
                    n_e     = r_cmd.span_start;
                    n_left  = r_cmd.rs_cnt;
                    n_state = B_SRD;
                end else begin
                    n_state = B_IDLE;
                end
            end
            B_PRD: begin
                n_ok    = w_ok;
                n_state = B_PWR;
            end
            B_PWR: begin
                w_we_pair = r_ok;
                if (r_left > 17'd1) begin
                    n_e     = r_e + 32'd1;
                    n_left  = r_left - 17'd1;
                    n_state = B_PRD;
                end else if (r_cmd.rs_cnt != '0) begin
                    n_e     = r_cmd.span_start;
                    n_left  = r_cmd.rs_cnt;
                    n_state = B_SRD;
                end else begin
                    n_state = B_IDLE;
                end
            end
            B_SRD: begin
                n_ok    = w_ok;
                n_state = B_SWR;
            end
            B_SWR: begin
                w_we_rs = r_ok;
                if (r_left > 17'd1) begin
                    n_e     = r_e + 32'd1;
                    n_left  = r_left - 17'd1;
                    n_state = B_SRD;
                end else begin
                    n_state = B_IDLE;
                end
            end
            B_ORD: begin
                // hold the read address until the output slot is free
                if (!r_out_valid) begin
                    n_state = B_OCAP;
                end
            end
            B_OCAP: begin
                n_out_valid = 1'b1;
                if (w_oor) begin
                    n_out = '0;
                end else begin
                    n_out.base_sum    = w_rd_base;
                    n_out.quality_sum = w_rd_q;
                    n_out.read_count  = w_rd_cnt;
                    n_out.span_pairs  = w_rd_pair;
                    n_out.span_reads  = w_rd_rs;
                end
                n_state = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_cmd  <= n_cmd;
        r_e    <= n_e;
        r_rem  <= n_rem;
        r_take <= n_take;
        r_left <= n_left;
        r_ok   <= n_ok;
        r_out  <= n_out;
    end

    assign o_clear_busy = (r_state == B_CLEAR);
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;

endmodule

// ===== design/read_coverage_binning.sv =====
// Read coverage binning top level: config registers, front end, queue, back end.
// Accumulate items need one to three divisions in the front on the shared radix-2
// divider, then a pop and a read state and a write state per bin touched in the back.
// Readout items pass through front, queue and back, with one bin store access.
// After reset a clearing pass zeroes all stores; no item is taken meanwhile.
// Depends on rcb_pkg, rcb_front, rcb_queue, rcb_back.
module read_coverage_binning (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  rcb_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output rcb_pkg::t_out_item         o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rcb_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [15:0]   r_bin_size;
    logic [7:0]    r_min_qual;
    logic          r_span_en;
    logic [15:0]   w_bs;

    logic          w_push;
    rcb_pkg::t_cmd w_cmd;
    logic          w_q_full;
    logic          w_pop;
    logic          w_q_valid;
    rcb_pkg::t_cmd w_q_data;
    logic          w_clear_busy;

    assign pready = 1'b1;
    assign w_bs   = (r_bin_size == '0) ? 16'd1 : r_bin_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_size <= rcb_pkg::BIN_SIZE_RST;
            r_min_qual <= rcb_pkg::MIN_QUAL_RST;
            r_span_en  <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                rcb_pkg::REG_BIN_SIZE: r_bin_size <= pwdata[15:0];
                rcb_pkg::REG_MIN_QUAL: r_min_qual <= pwdata[7:0];
                rcb_pkg::REG_SPAN_EN:  r_span_en  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            rcb_pkg::REG_BIN_SIZE: prdata = {16'b0, r_bin_size};
            rcb_pkg::REG_MIN_QUAL: prdata = {24'b0, r_min_qual};
            rcb_pkg::REG_SPAN_EN:  prdata = {31'b0, r_span_en};
            default:               prdata = '0;
        endcase
    end

    rcb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_bs         (w_bs),
        .i_min_q      (r_min_qual),
        .i_span_en    (r_span_en),
        .i_clear_busy (w_clear_busy),
        .o_push       (w_push),
        .o_cmd        (w_cmd),
        .i_q_full     (w_q_full)
    );

    rcb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    rcb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bs         (w_bs),
        .i_q_valid    (w_q_valid),
        .i_q_data     (w_q_data),
        .o_pop        (w_pop),
        .o_clear_busy (w_clear_busy),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

// ===== bench/tb_top.sv =====
// Testbench for read_coverage_binning: directed and random reads and readouts,
// checked against an in-bench model of the bin stores. Depends on rcb_pkg, read_coverage_binning.
`timescale 1ns / 1ps
module tb_top;
    import rcb_pkg::*;

    localparam logic [2:0] ST_USABLE = 3'd0;
    localparam int         CYCLE_LIMIT = 4000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    read_coverage_binning i_dut (.*);

    always #1 i_clk = ~i_clk;

    // model of the block
    bit [31:0] bases_m [NUM_BINS];
    bit [31:0] quals_m [NUM_BINS];
    bit [31:0] reads_m [NUM_BINS];
    bit [31:0] pairs_m [NUM_BINS];
    bit [31:0] rspan_m [NUM_BINS];
    bit [15:0] bin_size_m = BIN_SIZE_RST;
    bit [7:0]  min_qual_m = MIN_QUAL_RST;
    bit        span_en_m = 1'b0;

    t_out_item expected_bins [$];
    int        mismatches = 0;
    int        send_idle = 0;
    int        recv_idle = 0;
    longint    cycles = 0;

    function automatic bit [31:0] sat_add(bit [31:0] v, longint amt);
        longint s;
        s = longint'(v) + amt;
        return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic longint flat_bin(longint cbase, longint cbins, longint e);
        if (e < 0 || e >= cbins || cbase + e >= NUM_BINS) return -1;
        return cbase + e;
    endfunction

    function automatic longint ceil_div(longint n, longint d);
        if (n > 0) return (n + d - 1) / d;
        return -((-n) / d);
    endfunction

    function automatic void add_bases(longint cbase, longint cbins, longint e,
                                      longint take, longint mq);
        longint a;
        a = flat_bin(cbase, cbins, e);
        if (a >= 0) begin
            bases_m[a] = sat_add(bases_m[a], take);
            quals_m[a] = sat_add(quals_m[a], mq);
            reads_m[a] = sat_add(reads_m[a], 1);
        end
    endfunction

    function automatic void add_spans(bit pair_store, longint cbase, longint cbins,
                                      longint start, longint cnt);
        longint a;
        if (cnt > cbins - start) cnt = cbins - start;
        for (longint i = 0; i < cnt; i++) begin
            a = flat_bin(cbase, cbins, start + i);
            if (a >= 0) begin
                if (pair_store) pairs_m[a] = sat_add(pairs_m[a], 1);
                else rspan_m[a] = sat_add(rspan_m[a], 1);
            end
        end
    endfunction

    function automatic void bin_read(t_in_item it);
        longint bs, pos, len, e, off, take, rem, cnt, ins, cb, cn;
        t_out_item r;
        if (it.opcode == OP_READOUT) begin
            r.base_sum    = bases_m[it.bin_index];
            r.quality_sum = quals_m[it.bin_index];
            r.read_count  = reads_m[it.bin_index];
            r.span_pairs  = pairs_m[it.bin_index];
            r.span_reads  = rspan_m[it.bin_index];
            expected_bins = {expected_bins, r};
            return;
        end
        if (it.read_status == ST_LOW_QUAL || it.read_status == ST_UNMAPPED) return;
        bs  = (bin_size_m == 0) ? 1 : bin_size_m;
        pos = it.position;
        len = it.read_length;
        cb  = it.contig_base;
        cn  = it.contig_bins;
        ins = it.insert_size;
        e   = pos / bs;
        off = pos - e * bs;
        take = bs - off;
        if (take > len) take = len;
        rem = len;
        add_bases(cb, cn, e, take, it.map_quality);
        rem -= take;
        while (rem > 0 && e + 1 < cn) begin
            e++;
            take = (rem < bs) ? rem : bs;
            add_bases(cb, cn, e, take, it.map_quality);
            rem -= take;
        end
        if (it.read_status != ST_WRONG_DIST && it.read_status != ST_WRONG_ORIENT &&
            span_en_m && it.map_quality > min_qual_m) begin
            e = pos / bs;
            off = pos - e * bs;
            cnt = ceil_div(ins - bs + off, bs);
            // read starting near a bin edge: shift the span one bin on
            if (off < NEAR_EDGE) begin
                e++;
                cnt--;
            end
            add_spans(1'b1, cb, cn, e, cnt);
            if (!it.has_split_tag) begin
                cnt = ceil_div(len - bs + pos - e * bs, bs);
                add_spans(1'b0, cb, cn, e, cnt);
            end
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR: %s at cycle %0d", what, cycles);
        mismatches++;
    endtask

    task automatic check_field(string what, bit [31:0] got, bit [31:0] want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", what, got, want));
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        if (o_out_valid && i_out_ready) begin
            if (expected_bins.size() == 0) begin
                report_mismatch("unexpected result");
            end else begin
                want = expected_bins.pop_front();
                check_field("base_sum", o_out_data.base_sum, want.base_sum);
                check_field("quality_sum", o_out_data.quality_sum, want.quality_sum);
                check_field("read_count", o_out_data.read_count, want.read_count);
                check_field("span_pairs", o_out_data.span_pairs, want.span_pairs);
                check_field("span_reads", o_out_data.span_reads, want.span_reads);
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // valid drops at the falling edge after the accept; the next send_item raises it again
    task automatic send_item(t_in_item it);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle)
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        bin_read(it);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    function automatic t_in_item readout_of(bit [15:0] idx);
        t_in_item it;
        it = '0;
        it.opcode = OP_READOUT;
        it.bin_index = idx;
        return it;
    endfunction

    // a readout flushes every earlier read through the in-order pipe
    task automatic wait_idle();
        send_item(readout_of(16'($urandom_range(63))));
        while (expected_bins.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BIN_SIZE: bin_size_m = val[15:0];
            REG_MIN_QUAL: min_qual_m = val[7:0];
            REG_SPAN_EN:  span_en_m  = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(bit [15:0] bs, bit [7:0] mq, bit en);
        wait_idle();
        write_reg(REG_BIN_SIZE, 32'(bs));
        write_reg(REG_MIN_QUAL, 32'(mq));
        write_reg(REG_SPAN_EN, 32'(en));
    endtask

    function automatic t_in_item make_read(bit [2:0] st, bit [15:0] cb, bit [16:0] cn,
                                           bit [30:0] pos, bit [15:0] len, bit [7:0] mq,
                                           bit [31:0] ins, bit split);
        t_in_item it;
        it = '0;
        it.opcode = OP_ACCUM;
        it.read_status = st;
        it.contig_base = cb;
        it.contig_bins = cn;
        it.position = pos;
        it.read_length = len;
        it.map_quality = mq;
        it.insert_size = ins;
        it.has_split_tag = split;
        return it;
    endfunction

    task automatic test_directed();
        send_item(readout_of(16'd0));
        set_config(16'd100, 8'd0, 1'b1);
        for (int s = 0; s < 8; s++)
            send_item(make_read(3'(s), 16'd0, 17'd16, 31'(s * 37), 16'd250, 8'd30,
                                32'd400, 1'b0));
        send_item(make_read(ST_USABLE, 16'd2, 17'd8, 31'd5, 16'd0, 8'd255, 32'd0, 1'b1));
        send_item(make_read(ST_USABLE, 16'd4, 17'd0, 31'd0, 16'd50, 8'd20, 32'd300, 1'b0));
        send_item(make_read(ST_USABLE, 16'hFFFF, 17'h10000, 31'd0, 16'd350, 8'd40,
                            32'd250, 1'b0));
        send_item(make_read(ST_USABLE, 16'd8, 17'd6, 31'h7FFF_FFFF, 16'hFFFF, 8'd99,
                            32'h7FFF_FFFF, 1'b0));
        send_item(make_read(ST_USABLE, 16'd8, 17'd30, 31'd90, 16'hFFFF, 8'd99,
                            32'h7FFF_FFFF, 1'b0));
        send_item(make_read(ST_USABLE, 16'd8, 17'd30, 31'd150, 16'd10, 8'd99,
                            32'h8000_0000, 1'b0));
        for (int b = 0; b < 10; b++) send_item(readout_of(16'(b)));
        send_item(readout_of(16'hFFFF));
        send_item(readout_of(16'd20));
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        logic [159:0] raw;
        int bs;
        bit wide;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        bs = (bin_size_m == 0) ? 1 : bin_size_m;
        if ($urandom_range(99) < 30) begin
            it.opcode = OP_READOUT;
            if ($urandom_range(9) != 0) it.bin_index = 16'($urandom_range(80));
            return it;
        end
        it.opcode = OP_ACCUM;
        if ($urandom_range(99) < 70) it.read_status = ST_USABLE;
        if ($urandom_range(99) < 85) it.contig_base = 16'($urandom_range(48));
        wide = ($urandom_range(99) < 6);
        // large contigs only with short reads and inserts to bound the bins touched
        if (wide) it.contig_bins = $urandom_range(1) ? 17'h10000 : 17'($urandom);
        else it.contig_bins = 17'($urandom_range(32));
        if ($urandom_range(99) < 90) it.position = 31'($urandom_range(bs * 16));
        if (wide || $urandom_range(99) < 85)
            it.read_length = 16'($urandom_range(bs * 3 > 65535 ? 65535 : bs * 3));
        if (wide || $urandom_range(99) < 85)
            it.insert_size = 32'($urandom_range(bs * 10 > 1000000 ? 1000000 : bs * 10))
                             - 32'd50;
        return it;
    endfunction

    task automatic test_random(int n, int s_idle, int r_idle);
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int i = 0; i < n; i++) begin
            send_item(random_item());
            if ($urandom_range(199) == 0) wait_idle();
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        set_config(16'd1, 8'd255, 1'b1);
        test_random(300, 33, 87);
        set_config(16'd500, 8'd10, 1'b1);
        test_random(350, 87, 33);
        set_config(16'd65535, 8'd0, 1'b1);
        test_random(300, 0, 0);
        set_config(16'd0, 8'd60, 1'b1);
        test_random(300, 33, 87);
        set_config(16'd37, 8'd128, 1'b0);
        test_random(250, 87, 33);
        set_config(16'd21, 8'd5, 1'b1);
        test_random(250, 0, 0);
        while (expected_bins.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== files.f =====
design/rcb_pkg.sv
design/rcb_ram.sv
design/rcb_div.sv
design/rcb_front.sv
design/rcb_queue.sv
design/rcb_back.sv
design/read_coverage_binning.sv
bench/tb_top.sv
